[rtl/ctc_pkg.sv]
package ctc_pkg;

   // Field widths
   localparam int SCORE_W     = 17;
   localparam int CLASS_W     = 13;
   localparam int POS_W       = 16;
   localparam int STEP_W      = 10;
   localparam int WIDTH_W     = 16;
   localparam int TSTEPS_W    = 11;
   localparam int CCOUNT_W    = 14;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int OPCODE_W    = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 48;

   // Score format and limits
   localparam int FRAC_BITS   = 16;
   localparam logic [SCORE_W-1:0] ONE_Q = SCORE_W'(1) << FRAC_BITS;
   localparam int MAX_CLASSES = 8192;
   localparam int MAX_STEPS   = 1024;

   // Allowed-class mask memory organization
   localparam int MASK_ROW_W  = 32;
   localparam int MASK_ROWS   = MAX_CLASSES / MASK_ROW_W;
   localparam int BIT_IDX_W   = $clog2(MASK_ROW_W);
   localparam int ROW_IDX_W   = $clog2(MASK_ROWS);

   // Running-max sum and shared divider sizes
   localparam int SUM_W       = 30;
   localparam int MUL_W       = STEP_W + WIDTH_W;
   localparam int DIV_N_W     = SCORE_W + FRAC_BITS;
   localparam int DIV_D_W     = SUM_W;
   localparam int DIV_Q_W     = SCORE_W;
   localparam int DIV_CNT_W   = $clog2(DIV_Q_W + 1);

   // Decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_SCORE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ALLOW = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEPS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_COUNT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 2'd3;

   typedef struct packed {
      logic [WIDTH_W-1:0]  image_width;
      logic [TSTEPS_W-1:0] time_steps;
      logic [CCOUNT_W-1:0] class_count;
      logic                filter_enable;
   } cfg_type;

   // One classified score element on its way from front to back
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [CLASS_W-1:0] cls;
      logic               first;
      logic               eligible;
      logic               row_end;
   } elem_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [CLASS_W-1:0] class_index;
      logic [POS_W-1:0]   position;
      logic [SCORE_W-1:0] probability;
      logic               sequence_end;
   } rsp_type;

endpackage

[rtl/ctc_greedy_decoder.sv]
// CTC greedy decoder. Class scores stream in one per request, class_count
// scores per row and time_steps rows per sequence; the block takes each row's
// argmax and returns a symbol when it is neither blank nor the previous row's
// argmax, carrying its image column and the running product of its scores,
// then one summary item (tlast high) at the end of each sequence. Score
// elements stream back to back, one per cycle, through a four-entry queue
// while it has room and no clear pass runs. A row end that emits a symbol
// holds the back end for one 17-step pass of the shared iterative divider
// for the position, two multiply steps and one output step, and in filter
// mode for a second divider pass that normalizes the score. After reset
// and after each clear-mask request a clear pass sweeps the 256 rows of
// the allowed-class mask, one 32-bit row per cycle, during which no request
// is taken; configuration writes are taken at any time.
module ctc_greedy_decoder (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [16:0] score, [29:17] class_number, [31:30] zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [12:0] class_index, [28:13] position,
                                    // [45:29] probability, [47:46] zero
   output logic        rsp_tlast,   // sequence_end
   // Configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import ctc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   elem_type q_in_data;
   elem_type q_out_data;
   logic     back_valid;
   rsp_type  back_data;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata[WIDTH_W-1:0];
            CSR_TIME_STEPS:    cfg_in.time_steps    = csr_wdata[TSTEPS_W-1:0];
            CSR_CLASS_COUNT:   cfg_in.class_count   = csr_wdata[CCOUNT_W-1:0];
            CSR_FILTER_ENABLE: cfg_in.filter_enable = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= WIDTH_W'(1);
         cfg_ff.time_steps    <= TSTEPS_W'(1);
         cfg_ff.class_count   <= CCOUNT_W'(2);
         cfg_ff.filter_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ctc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_opcode       (req_tuser[OPCODE_W-1:0]),
      .req_score        (req_tdata[SCORE_W-1:0]),
      .req_class_number (req_tdata[SCORE_W +: CLASS_W]),
      .q_push           (q_push),
      .q_data           (q_in_data),
      .q_full           (q_full)
   );

   ctc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out_data)
   );

   ctc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_out_data),
      .q_pop     (q_pop),
      .rsp_valid (back_valid),
      .rsp_ready (rsp_tready),
      .rsp_data  (back_data)
   );

   // Pack the result item
   assign rsp_tvalid = back_valid;
   assign rsp_tlast  = back_data.sequence_end;
   assign rsp_tdata  = {(RSP_DATA_W - CLASS_W - POS_W - SCORE_W)'(0),
                        back_data.probability, back_data.position,
                        back_data.class_index};

   // A clear pass follows every reset, so no request is taken right after
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during the post-reset clear pass");

   // Summary items carry class 0 at column 0
   a_summary_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[CLASS_W+POS_W-1:0] == '0))
      else $error("summary item with nonzero class or position");

   // Symbol items never carry the blank class
   a_symbol_nonblank: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[CLASS_W-1:0] != '0))
      else $error("blank class emitted as a symbol");

   // The running product never exceeds 1.0
   a_prob_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CLASS_W+POS_W +: SCORE_W] <= ONE_Q))
      else $error("probability above 1.0");

endmodule

[rtl/ctc_front.sv]
module ctc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  ctc_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ctc_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [ctc_pkg::SCORE_W-1:0]  req_score,
   input  logic [ctc_pkg::CLASS_W-1:0]  req_class_number,
   output logic                      q_push,
   output ctc_pkg::elem_type         q_data,
   input  logic                      q_full
);
   import ctc_pkg::*;

   logic [MASK_ROW_W-1:0] mask_mem [MASK_ROWS];
   logic [MASK_ROW_W-1:0] mask_rd_ff;

   logic [CLASS_W-1:0]    elem_ff, elem_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [ROW_IDX_W-1:0]  clr_row_ff, clr_row_in;
   logic                  s1_valid_ff, s1_valid_in;
   elem_type              s1_ff, s1_in;

   logic                  accept;
   logic                  take_score;
   logic [CCOUNT_W-1:0]   cls_lim;
   logic                  row_end;
   logic [SCORE_W-1:0]    score_clamped;

   // Accept while no clear pass runs and the staging slot can move on
   assign req_ready  = !clr_busy_ff && (!s1_valid_ff || !q_full);
   assign accept     = req_valid && req_ready;
   assign take_score = accept && (req_opcode == OP_SCORE);
   assign q_push     = s1_valid_ff && !q_full;

   // Saturate the class count, find the row end and clamp the score to 1.0
   always_comb begin
      if (cfg.class_count < CCOUNT_W'(2)) begin
         cls_lim = CCOUNT_W'(2);
      end else if (cfg.class_count > CCOUNT_W'(MAX_CLASSES)) begin
         cls_lim = CCOUNT_W'(MAX_CLASSES);
      end else begin
         cls_lim = cfg.class_count;
      end
      row_end = (CCOUNT_W'(elem_ff) + CCOUNT_W'(1)) >= cls_lim;
      score_clamped = (req_score > ONE_Q) ? ONE_Q : req_score;
   end

   // Advance the element counter and stage each score element
   always_comb begin
      elem_in     = elem_ff;
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (q_push) begin
         s1_valid_in = 1'b0;
      end
      if (take_score) begin
         elem_in           = row_end ? '0 : elem_ff + CLASS_W'(1);
         s1_valid_in       = 1'b1;
         s1_in.score       = score_clamped;
         s1_in.cls         = elem_ff;
         s1_in.first       = (elem_ff == '0);
         s1_in.eligible    = 1'b0;
         s1_in.row_end     = row_end;
      end
   end

   // Run a clear pass after reset and on every clear request
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         clr_row_in = clr_row_ff + ROW_IDX_W'(1);
         if (clr_row_ff == ROW_IDX_W'(MASK_ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end else if (accept && (req_opcode == OP_CLEAR)) begin
         clr_busy_in = 1'b1;
         clr_row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_ff     <= '0;
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         elem_ff     <= elem_in;
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // Mask memory: row clear, single-bit set, registered row read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mask_mem[clr_row_ff] <= '0;
      end else if (accept && (req_opcode == OP_ALLOW)) begin
         mask_mem[req_class_number[CLASS_W-1:BIT_IDX_W]]
            [req_class_number[BIT_IDX_W-1:0]] <= 1'b1;
      end
      if (take_score) begin
         mask_rd_ff <= mask_mem[elem_ff[CLASS_W-1:BIT_IDX_W]];
      end
   end

   // Blank is always allowed; outside filter mode every class is
   always_comb begin
      q_data          = s1_ff;
      q_data.eligible = !cfg.filter_enable || s1_ff.first ||
                        mask_rd_ff[s1_ff.cls[BIT_IDX_W-1:0]];
   end

endmodule

[rtl/ctc_queue.sv]
module ctc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ctc_pkg::elem_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output ctc_pkg::elem_type pop_data
);
   import ctc_pkg::*;

   elem_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   // Move pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/ctc_div.sv]
module ctc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ctc_pkg::div_req_type req,
   output ctc_pkg::div_rsp_type rsp
);
   import ctc_pkg::*;

   // Restoring divider, one quotient bit per cycle. Callers guarantee
   // that the quotient fits in DIV_Q_W bits.
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIV_Q_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         // Load the high part of the dividend as the partial remainder
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_Q_W);
         rem_in  = DIV_D_W'(req.dividend[DIV_N_W-1:DIV_Q_W]);
         quo_in  = req.dividend[DIV_Q_W-1:0];
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_Q_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[rtl/ctc_back.sv]
module ctc_back (
   input  logic              clock,
   input  logic              reset,
   input  ctc_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  ctc_pkg::elem_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ctc_pkg::rsp_type  rsp_data
);
   import ctc_pkg::*;

   typedef enum logic [6:0] {
      ST_RUN      = 7'b0000001,
      ST_POS_MUL  = 7'b0000010,
      ST_POS_DIV  = 7'b0000100,
      ST_FAC_DIV  = 7'b0001000,
      ST_PROD_MUL = 7'b0010000,
      ST_EMIT_SYM = 7'b0100000,
      ST_EMIT_END = 7'b1000000
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [SCORE_W-1:0]   best_score_ff, best_score_in;
   logic [CLASS_W-1:0]   best_class_ff, best_class_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CLASS_W-1:0]   prev_ff, prev_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [SCORE_W-1:0]   prod_ff, prod_in;
   logic                 last_ff, last_in;
   logic [MUL_W-1:0]     mul_ff, mul_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [SCORE_W-1:0]   factor_ff, factor_in;
   logic                 div_start_ff, div_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [TSTEPS_W-1:0]  steps_lim;
   logic                 upd;
   logic                 seq_last;
   logic                 emit;
   logic                 slot_free;
   logic [2*SCORE_W-1:0] prod_wide;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   ctc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Saturate the step count
   always_comb begin
      if (cfg.time_steps < TSTEPS_W'(1)) begin
         steps_lim = TSTEPS_W'(1);
      end else if (cfg.time_steps > TSTEPS_W'(MAX_STEPS)) begin
         steps_lim = TSTEPS_W'(MAX_STEPS);
      end else begin
         steps_lim = cfg.time_steps;
      end
   end

   assign q_pop     = q_valid && (state_ff == ST_RUN);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign seq_last  = (TSTEPS_W'(step_ff) + TSTEPS_W'(1)) >= steps_lim;
   assign prod_wide = (2*SCORE_W)'(prod_ff) * (2*SCORE_W)'(factor_ff);

   // Shared divider: position first, then the normalized factor
   always_comb begin
      div_req.start = div_start_ff;
      if (state_ff == ST_FAC_DIV) begin
         div_req.dividend = {best_score_ff, FRAC_BITS'(0)};
         div_req.divisor  = sum_ff;
      end else begin
         div_req.dividend = DIV_N_W'(mul_ff);
         div_req.divisor  = DIV_D_W'(steps_lim);
      end
   end

   // Argmax update for the element at the queue head
   always_comb begin
      upd           = q_data.first ||
                      (q_data.eligible && (q_data.score > best_score_ff));
      best_score_in = best_score_ff;
      best_class_in = best_class_ff;
      sum_in        = sum_ff;
      if (q_pop && q_data.first) begin
         best_score_in = q_data.score;
         best_class_in = '0;
         sum_in        = SUM_W'(q_data.score);
      end else if (q_pop && upd) begin
         best_score_in = q_data.score;
         best_class_in = q_data.cls;
         sum_in        = sum_ff + SUM_W'(q_data.score);
      end
      emit = (best_class_in != '0) && (best_class_in != prev_ff);
   end

   // Row-end sequencer and output register
   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      last_in      = last_ff;
      mul_in       = mul_ff;
      pos_in       = pos_ff;
      factor_in    = factor_ff;
      div_start_in = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_RUN: begin
            if (q_pop && q_data.row_end) begin
               prev_in = best_class_in;
               last_in = seq_last;
               if (emit) begin
                  state_in = ST_POS_MUL;
               end else if (seq_last) begin
                  state_in = ST_EMIT_END;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         ST_POS_MUL: begin
            mul_in       = MUL_W'(step_ff) * MUL_W'(cfg.image_width);
            div_start_in = 1'b1;
            state_in     = ST_POS_DIV;
         end
         ST_POS_DIV: begin
            if (div_rsp.done) begin
               pos_in = div_rsp.quotient[POS_W-1:0];
               if (!cfg.filter_enable) begin
                  factor_in = best_score_ff;
                  state_in  = ST_PROD_MUL;
               end else if (sum_ff == '0) begin
                  factor_in = '0;
                  state_in  = ST_PROD_MUL;
               end else begin
                  div_start_in = 1'b1;
                  state_in     = ST_FAC_DIV;
               end
            end
         end
         ST_FAC_DIV: begin
            if (div_rsp.done) begin
               factor_in = div_rsp.quotient;
               state_in  = ST_PROD_MUL;
            end
         end
         ST_PROD_MUL: begin
            prod_in  = prod_wide[FRAC_BITS +: SCORE_W];
            state_in = ST_EMIT_SYM;
         end
         ST_EMIT_SYM: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.class_index  = best_class_ff;
               rsp_in.position     = pos_ff;
               rsp_in.probability  = prod_ff;
               rsp_in.sequence_end = 1'b0;
               if (last_ff) begin
                  state_in = ST_EMIT_END;
               end else begin
                  step_in  = step_ff + STEP_W'(1);
                  state_in = ST_RUN;
               end
            end
         end
         ST_EMIT_END: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.class_index  = '0;
               rsp_in.position     = '0;
               rsp_in.probability  = prod_ff;
               rsp_in.sequence_end = 1'b1;
               step_in             = '0;
               prev_in             = '0;
               prod_in             = ONE_Q;
               state_in            = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         best_score_ff <= '0;
         best_class_ff <= '0;
         sum_ff        <= '0;
         prev_ff       <= '0;
         step_ff       <= '0;
         prod_ff       <= ONE_Q;
         last_ff       <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_score_ff <= best_score_in;
         best_class_ff <= best_class_in;
         sum_ff        <= sum_in;
         prev_ff       <= prev_in;
         step_ff       <= step_in;
         prod_ff       <= prod_in;
         last_ff       <= last_in;
         div_start_ff  <= div_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff    <= mul_in;
      pos_ff    <= pos_in;
      factor_ff <= factor_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
